/* rtl/crsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsv_pkg
// Beat types, header layout constants and the byte-wide CRC-32 update for
// the record slot validator.
// ----------------------------------------------------------------------------
package crsv_pkg;

  // Widths
  localparam int unsigned CAP_W  = 12;   // capacity and payload length
  localparam int unsigned POS_W  = 13;   // byte position within the slot
  localparam int unsigned BYTE_W = 8;

  // Slot geometry
  localparam int unsigned SLOT_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned PAYLOAD_MAX  = SLOT_BYTES - HEADER_BYTES;

  // Header word offsets (little-endian 32-bit words)
  localparam int unsigned HDR_LEN_POS  = 4;
  localparam int unsigned HDR_CRC_POS  = 8;
  localparam int unsigned HDR_RSVD_POS = 12;

  // Length byte lanes
  localparam logic [1:0] LANE_B0 = 2'd0;
  localparam logic [1:0] LANE_B1 = 2'd1;
  localparam logic [1:0] LANE_B2 = 2'd2;
  localparam logic [1:0] LANE_B3 = 2'd3;

  localparam logic [31:0] REC_MAGIC = 32'h3143_4E54;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 12'd4080;

  // Input beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              read_error;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic             record_valid;
    logic [CAP_W-1:0] payload_length;
  } out_beat_t;

  // Result handed from the core to the output buffer
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } result_t;

  // Reflected CRC-32, one byte; flattens to an XOR network
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [BYTE_W-1:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

/* rtl/crsv_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsv_core
// Slot parser: header capture and checks, payload CRC, verdict generation.
// One beat per cycle; state advances only when beat_valid is high.
// ----------------------------------------------------------------------------
module crsv_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     beat_valid,
  input  crsv_pkg::in_beat_t       beat,
  input  logic [crsv_pkg::CAP_W-1:0] capacity,
  output crsv_pkg::result_t        res
);
  import crsv_pkg::*;

  // Slot state
  logic [POS_W-1:0] pos_r,      pos_nxt;
  logic             magic_ok_r, magic_ok_nxt;
  logic [CAP_W-1:0] len_r,      len_nxt;
  logic             len_hi_r,   len_hi_nxt;   // length >= 4096
  logic [31:0]      exp_crc_r,  exp_crc_nxt;
  logic [31:0]      crc_r,      crc_nxt;
  logic             given_r,    given_nxt;

  // Values after a first-byte restart
  logic [POS_W-1:0] pos_e;
  logic             magic_ok_e;
  logic [CAP_W-1:0] len_e;
  logic             len_hi_e;
  logic [31:0]      exp_crc_e;
  logic [31:0]      crc_e;
  logic             given_e;

  logic [1:0]        lane;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] magic_byte;
  logic              hdr_bad;
  logic [POS_W-1:0]  paid;

  always_comb begin
    b    = beat.data_byte;

    pos_e      = beat.first_byte ? '0       : pos_r;
    magic_ok_e = beat.first_byte ? 1'b1     : magic_ok_r;
    len_e      = beat.first_byte ? '0       : len_r;
    len_hi_e   = beat.first_byte ? 1'b0     : len_hi_r;
    exp_crc_e  = beat.first_byte ? '0       : exp_crc_r;
    crc_e      = beat.first_byte ? CRC_INIT : crc_r;
    given_e    = beat.first_byte ? 1'b0     : given_r;

    lane = pos_e[1:0];

    pos_nxt      = pos_e;
    magic_ok_nxt = magic_ok_e;
    len_nxt      = len_e;
    len_hi_nxt   = len_hi_e;
    exp_crc_nxt  = exp_crc_e;
    crc_nxt      = crc_e;
    given_nxt    = given_e;

    magic_byte = BYTE_W'(REC_MAGIC >> {lane, 3'b000});
    hdr_bad    = 1'b0;
    paid       = '0;
    res        = '0;

    if (!given_e) begin
      priority if (beat.read_error) begin
        // rejected at once
        given_nxt = 1'b1;
        res.valid = 1'b1;
      end else if (pos_e < POS_W'(HEADER_BYTES)) begin
        pos_nxt = pos_e + POS_W'(1);
        priority if (pos_e < POS_W'(HDR_LEN_POS)) begin
          magic_ok_nxt = magic_ok_e && (b == magic_byte);
        end else if (pos_e < POS_W'(HDR_CRC_POS)) begin
          unique case (lane)
            LANE_B0: len_nxt[7:0] = b;
            LANE_B1: begin
              len_nxt[CAP_W-1:8] = b[CAP_W-9:0];
              len_hi_nxt = len_hi_e || (b[BYTE_W-1:CAP_W-8] != '0);
            end
            LANE_B2, LANE_B3: len_hi_nxt = len_hi_e || (b != '0);
            default: len_hi_nxt = len_hi_e;
          endcase
        end else if (pos_e < POS_W'(HDR_RSVD_POS)) begin
          exp_crc_nxt[{lane, 3'b000} +: BYTE_W] = b;
        end else begin
          // reserved word is skipped
        end

        // header complete: magic, bounds, capacity
        if (pos_e == POS_W'(HEADER_BYTES - 1)) begin
          hdr_bad = !magic_ok_e || len_hi_e || (len_e == '0) ||
                    ({20'd0, len_e} > 32'(PAYLOAD_MAX)) || (len_e > capacity);
          if (hdr_bad) begin
            given_nxt = 1'b1;
            res.valid = 1'b1;
          end
        end
      end else begin
        // payload byte
        crc_nxt = crc_byte(crc_e, b);
        pos_nxt = pos_e + POS_W'(1);
        paid    = pos_nxt - POS_W'(HEADER_BYTES);
        if (paid >= {1'b0, len_e}) begin
          given_nxt = 1'b1;
          res.valid = 1'b1;
          res.beat.record_valid = (~crc_nxt == exp_crc_e);
          res.beat.payload_length = (~crc_nxt == exp_crc_e) ? len_e : '0;
        end
      end
    end

    if (!beat_valid) begin
      res.valid = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      magic_ok_r <= 1'b1;
      len_r      <= '0;
      len_hi_r   <= 1'b0;
      exp_crc_r  <= '0;
      crc_r      <= CRC_INIT;
      given_r    <= 1'b1;
    end else if (beat_valid) begin
      pos_r      <= pos_nxt;
      magic_ok_r <= magic_ok_nxt;
      len_r      <= len_nxt;
      len_hi_r   <= len_hi_nxt;
      exp_crc_r  <= exp_crc_nxt;
      crc_r      <= crc_nxt;
      given_r    <= given_nxt;
    end
  end

endmodule

/* rtl/crsv_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsv_out_buf
// Two-entry result buffer: output register plus skid entry. The full flag
// comes straight from a register, so upstream never sees out_ready.
// ----------------------------------------------------------------------------
module crsv_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  crsv_pkg::result_t   push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output crsv_pkg::out_beat_t out_data
);
  import crsv_pkg::*;

  logic      main_v_r, main_v_nxt;
  out_beat_t main_r,   main_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_beat_t skid_r,   skid_nxt;
  logic      pop;

  assign pop       = main_v_r && out_ready;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // Next-state: skid drains into main first; a push lands wherever free
  always_comb begin
    main_v_nxt = main_v_r;
    main_nxt   = main_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (pop) begin
      main_v_nxt = skid_v_r;
      main_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end
    if (push.valid) begin
      if (!main_v_nxt) begin
        main_v_nxt = 1'b1;
        main_nxt   = push.beat;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push.beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

/* rtl/crc_record_slot_validator_unit.sv */
`timescale 1ns / 1ps
// An accepted byte is held in the input register; the parse/CRC logic then writes
//   its result into the result buffer, whose output register drives out_valid.
// Throughput: 1 byte per cycle; the byte-wide CRC-32 update is a flat XOR network.
//   The input stalls only while both result buffer entries wait on out_ready.
// Reset (rst_n low, synchronous): capacity 4080, parser idle until a byte
//   with first_byte, buffers empty. No clearing pass.
// ----------------------------------------------------------------------------
// crc_record_slot_validator_unit
// Flash record slot validator: header check and payload CRC-32 per slot.
// ----------------------------------------------------------------------------
module crc_record_slot_validator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  crsv_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output crsv_pkg::out_beat_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [crsv_pkg::CAP_W-1:0]   cfg_data
);
  import crsv_pkg::*;

  logic             in_v_r;
  in_beat_t         in_q_r;
  logic [CAP_W-1:0] capacity_r;
  logic             buf_full;
  logic             advance;
  result_t          res;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // Input register
  assign advance  = in_v_r && !buf_full;
  assign in_ready = !in_v_r || !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
  end

  // Parser and CRC
  crsv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (advance),
    .beat       (in_q_r),
    .capacity   (capacity_r),
    .res        (res)
  );

  // Result buffer
  crsv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/crsv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsv_checker
// Port-level checks on the result channel of the slot validator.
// ----------------------------------------------------------------------------
module crsv_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input crsv_pkg::out_beat_t        out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Rejected slots report zero length
  a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.record_valid |-> out_data.payload_length == '0)
    else $error("invalid verdict with nonzero length");

  // Valid slots never report an empty payload
  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_valid |-> out_data.payload_length != '0)
    else $error("valid verdict with zero length");

  // Reset empties the result channel and the input stage accepts again
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result or stall survived reset");

endmodule

bind crc_record_slot_validator_unit crsv_checker u_crsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
